// ----- rtl/cht_pkg.sv -----
// Shared types, sizes and codes of the chained hash table.
// Depends on nothing; every other file of the block but cht_ram imports it.
`default_nettype none
package cht_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int CHAIN_DEPTH = 8;
    localparam int SLOT_TOTAL  = MAX_BUCKETS * CHAIN_DEPTH;
    localparam int BUCKET_W    = $clog2(MAX_BUCKETS);
    localparam int POS_W       = $clog2(CHAIN_DEPTH);
    localparam int LEN_W       = POS_W + 1;
    localparam int SLOT_AW     = BUCKET_W + POS_W;
    localparam int COUNT_W     = 10;
    localparam int CFG_W       = 7;
    localparam int DATA_W      = 32;
    localparam int HASH_W      = 30;
    localparam int PROD_W      = 39;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_W       = 48;

    localparam logic [HASH_W-1:0] HASH_MOD    = 30'd1000000007;
    localparam logic [8:0]        HASH_BASE   = 9'd311;
    localparam logic [31:0]       DIV10_MAGIC = 32'hCCCCCCCD;

    localparam logic [CFG_W-1:0] BUCKETS_MAX = CFG_W'(MAX_BUCKETS);
    localparam logic [LEN_W-1:0] CHAIN_FULL  = LEN_W'(CHAIN_DEPTH);

    localparam logic [1:0] REQ_GET   = 2'd0;
    localparam logic [1:0] REQ_PUT   = 2'd1;
    localparam logic [1:0] REQ_ERASE = 2'd2;
    localparam logic [1:0] REQ_HAS   = 2'd3;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef struct packed {
        logic [1:0]          req;
        logic [DATA_W-1:0]   key;
        logic [DATA_W-1:0]   new_value;
        logic [BUCKET_W-1:0] bucket;
    } cht_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] key;
    } cht_slot_t;

endpackage
`default_nettype wire

// ----- rtl/chained_hash_table.sv -----
// Top level of the chained hash table: config register, front end, queue, table engine.
// Depends on cht_pkg, cht_front, cht_fifo, cht_back (and cht_ram through cht_back).
//
//   channel  | direction | handshake          | word contents
//   ---------+-----------+--------------------+---------------------------------------
//   s_       | in        | s_tvalid/s_tready  | tdata: key, new_value; tuser: req_type
//   m_       | out       | m_tvalid/m_tready  | tdata: found, read_value, status, total
//   cfg_     | in        | cfg_valid/cfg_ready| cfg_data: bucket_count
//
// The front end accepts a request, works through a positive key one decimal digit
// at a time (its divide-by-ten and mod 1e9+7 reduction steps), then reduces the
// hash bit by bit to the bucket remainder and pushes; a zero or negative key goes
// straight to the push. It takes one request at a time; this sets the rate.
// The table engine reads the chain length, walks the chain slot by slot, then decides;
// an erase that moves the last entry also passes B_MOVE; it overlaps the next hash via the queue.
// Reset clears the queue, chain lengths and entry count at once; no sweep.
// A stalled result word holds in the output register; the front keeps hashing until the queue is full.
`default_nettype none
module chained_hash_table import cht_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,    // [31:0] key, [63:32] new_value
    input  logic [1:0]       s_tuser,    // [1:0] req_type
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,    // [0] found, [32:1] read_value, [34:33] status,
                                         // [44:35] entry_total, [47:45] zero
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] bucket_count_reg;
    logic             push_valid, queue_full, queue_empty, pop;
    cht_item_t        push_item, head;

    // Take config words at any time; the user must send them only while idle, the block does not enforce it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= CFG_W'(1);
        end else if (cfg_valid) begin
            bucket_count_reg <= cfg_data;
        end
    end

    cht_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .bucket_count(bucket_count_reg),
        .push_valid(push_valid), .push_item(push_item), .queue_full(queue_full)
    );

    cht_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push_valid(push_valid), .push_item(push_item), .full(queue_full),
        .pop(pop), .head(head), .empty(queue_empty)
    );

    cht_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .empty(queue_empty), .head(head), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

endmodule
`default_nettype wire

// ----- rtl/cht_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- rtl/cht_front.sv -----
// Front end: accepts request words and hashes the key into a bucket.
// Depends on cht_pkg.
`default_nettype none
module cht_front import cht_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,
    input  logic [1:0]       s_tuser,
    input  logic [CFG_W-1:0] bucket_count,
    output logic             push_valid,
    output cht_item_t        push_item,
    input  logic             queue_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_MOD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [2:0]          step_reg, step_next;
    logic [4:0]          bitcnt_reg, bitcnt_next;
    logic [1:0]          req_reg, req_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [DATA_W-1:0]   nv_reg, nv_next;
    logic [DATA_W-1:0]   k_reg, k_next;
    logic [28:0]         qk_reg, qk_next;
    logic [HASH_W-1:0]   h_reg, h_next;
    logic [PROD_W-1:0]   x_reg, x_next;
    logic [BUCKET_W-1:0] r_reg, r_next;

    logic [63:0]         prod;
    logic [31:0]         qk10;
    logic [3:0]          digit;
    logic [PROD_W-1:0]   x_red;
    logic [PROD_W-1:0]   x_fin;
    logic [CFG_W-1:0]    n_eff;
    logic [BUCKET_W:0]   r_shift;
    logic [BUCKET_W:0]   r_mod;

    assign prod  = k_reg * DIV10_MAGIC;
    assign qk10  = {qk_reg, 3'b000} + {2'b00, qk_reg, 1'b0};
    assign digit = 4'(k_reg - qk10);
    assign x_red = x_reg - PROD_W'(x_reg[PROD_W-1:HASH_W] * HASH_MOD);
    assign x_fin = (x_reg >= PROD_W'(HASH_MOD)) ? x_reg - PROD_W'(HASH_MOD) : x_reg;

    assign n_eff = (bucket_count == '0) ? CFG_W'(1) :
                   (bucket_count > BUCKETS_MAX) ? BUCKETS_MAX : bucket_count;
    assign r_shift = {r_reg, h_reg[HASH_W-1]};
    assign r_mod   = (CFG_W'(r_shift) >= n_eff) ? r_shift - (BUCKET_W+1)'(n_eff) : r_shift;

    assign s_tready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_item  = '{req: req_reg, key: key_reg, new_value: nv_reg, bucket: r_reg};

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        bitcnt_next = bitcnt_reg;
        req_next    = req_reg;
        key_next    = key_reg;
        nv_next     = nv_reg;
        k_next      = k_reg;
        qk_next     = qk_reg;
        h_next      = h_reg;
        x_next      = x_reg;
        r_next      = r_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    req_next = s_tuser;
                    key_next = s_tdata[31:0];
                    nv_next  = s_tdata[63:32];
                    k_next   = s_tdata[31:0];
                    h_next   = '0;
                    r_next   = '0;
                    step_next = '0;
                    // zero and negative keys land in bucket zero
                    if (!s_tdata[31] && (s_tdata[31:0] != '0)) begin
                        state_next = F_HASH;
                    end else begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_HASH: begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: begin
                        qk_next = prod[63:35];
                        x_next  = PROD_W'(h_reg * HASH_BASE);
                    end
                    3'd1: begin
                        x_next = x_reg + PROD_W'(digit) + PROD_W'(1);
                        k_next = {3'b000, qk_reg};
                    end
                    3'd2, 3'd3, 3'd4: begin
                        x_next = x_red;
                    end
                    default: begin
                        h_next    = x_fin[HASH_W-1:0];
                        step_next = '0;
                        if (k_reg == '0) begin
                            state_next  = F_MOD;
                            bitcnt_next = 5'(HASH_W - 1);
                        end
                    end
                endcase
            end
            F_MOD: begin
                r_next      = r_mod[BUCKET_W-1:0];
                h_next      = {h_reg[HASH_W-2:0], 1'b0};
                bitcnt_next = bitcnt_reg - 5'd1;
                if (bitcnt_reg == '0) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!queue_full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        bitcnt_reg <= bitcnt_next;
        req_reg    <= req_next;
        key_reg    <= key_next;
        nv_reg     <= nv_next;
        k_reg      <= k_next;
        qk_reg     <= qk_next;
        h_reg      <= h_next;
        x_reg      <= x_next;
        r_reg      <= r_next;
    end

endmodule
`default_nettype wire

// ----- rtl/cht_fifo.sv -----
// Short queue of hashed requests between the front end and the table engine.
// Depends on cht_pkg.
`default_nettype none
module cht_fifo import cht_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    input  cht_item_t push_item,
    output logic      full,
    input  logic      pop,
    output cht_item_t head,
    output logic      empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cht_item_t        entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic             do_push, do_pop;

    assign full    = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign head    = entries[rptr_reg];
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= wptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cht_back.sv -----
// Table engine: walks a bucket's chain, applies the request, drives result words.
// Depends on cht_pkg and cht_ram.
`default_nettype none
module cht_back import cht_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             empty,
    input  cht_item_t        head,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_LEN    = 3'd1;
    localparam logic [2:0] B_WALK   = 3'd2;
    localparam logic [2:0] B_DECIDE = 3'd3;
    localparam logic [2:0] B_MOVE   = 3'd4;

    logic [2:0]             state_reg, state_next;
    cht_item_t              item_reg, item_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   hit_reg, hit_next;
    logic [DATA_W-1:0]      hval_reg, hval_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [MAX_BUCKETS-1:0] valid_reg, valid_next;
    logic                   mv_reg, mv_next;
    logic [OUT_W-1:0]       md_reg, md_next;

    logic                len_we;
    logic [LEN_W-1:0]    len_wdata, len_rdata, len_cur;
    logic [BUCKET_W-1:0] len_raddr;
    logic                slot_we;
    logic [SLOT_AW-1:0]  slot_waddr, slot_raddr;
    cht_slot_t           slot_wdata, slot_rdata;

    logic                out_free, emit;
    logic                res_found;
    logic [DATA_W-1:0]   res_rv;
    logic [1:0]          res_status;
    logic [LEN_W-1:0]    pos_inc;
    logic [POS_W-1:0]    last_pos;
    logic [DATA_W-1:0]   put_val;

    cht_ram #(.WIDTH(LEN_W), .DEPTH(MAX_BUCKETS)) u_len_ram (
        .clk(aclk), .we(len_we), .waddr(item_reg.bucket), .wdata(len_wdata),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    cht_ram #(.WIDTH(2 * DATA_W), .DEPTH(SLOT_TOTAL)) u_slot_ram (
        .clk(aclk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_raddr), .rdata(slot_rdata)
    );

    assign out_free = !mv_reg || m_tready;
    assign pos_inc  = {1'b0, pos_reg} + LEN_W'(1);
    assign last_pos = POS_W'(len_reg - LEN_W'(1));
    assign put_val  = (item_reg.req == REQ_PUT) ? item_reg.new_value : '0;
    assign len_cur  = valid_reg[item_reg.bucket] ? len_rdata : '0;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    always_comb begin
        state_next = state_reg;
        item_next  = item_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        hit_next   = hit_reg;
        hval_next  = hval_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        pop        = 1'b0;
        len_we     = 1'b0;
        len_wdata  = len_reg;
        len_raddr  = head.bucket;
        slot_we    = 1'b0;
        slot_waddr = {item_reg.bucket, pos_reg};
        slot_wdata = '{value: put_val, key: item_reg.key};
        slot_raddr = {item_reg.bucket, pos_reg};
        emit       = 1'b0;
        res_found  = 1'b0;
        res_rv     = '0;
        res_status = STATUS_OK;
        case (state_reg)
            B_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    item_next  = head;
                    state_next = B_LEN;
                end
            end
            B_LEN: begin
                len_next   = len_cur;
                pos_next   = '0;
                hit_next   = 1'b0;
                slot_raddr = {item_reg.bucket, {POS_W{1'b0}}};
                state_next = (len_cur == '0) ? B_DECIDE : B_WALK;
            end
            B_WALK: begin
                if (slot_rdata.key == item_reg.key) begin
                    hit_next   = 1'b1;
                    hval_next  = slot_rdata.value;
                    state_next = B_DECIDE;
                end else if (pos_inc == len_reg) begin
                    state_next = B_DECIDE;
                end else begin
                    pos_next   = pos_inc[POS_W-1:0];
                    slot_raddr = {item_reg.bucket, pos_inc[POS_W-1:0]};
                end
            end
            B_DECIDE: begin
                slot_raddr = {item_reg.bucket, last_pos};
                if (out_free) begin
                    emit = 1'b1;
                    case (item_reg.req)
                        REQ_GET, REQ_PUT: begin
                            if (hit_reg) begin
                                res_found = 1'b1;
                                if (item_reg.req == REQ_PUT) begin
                                    slot_we = 1'b1;
                                    res_rv  = item_reg.new_value;
                                end else begin
                                    res_rv  = hval_reg;
                                end
                            end else if (len_reg == CHAIN_FULL) begin
                                res_status = STATUS_FULL;
                            end else begin
                                // append at the chain's end
                                slot_we    = 1'b1;
                                slot_waddr = {item_reg.bucket, len_reg[POS_W-1:0]};
                                res_rv     = put_val;
                                len_we     = 1'b1;
                                len_wdata  = len_reg + LEN_W'(1);
                                valid_next[item_reg.bucket] = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                        REQ_ERASE: begin
                            if (!hit_reg) begin
                                res_status = STATUS_NOTFOUND;
                            end else if (pos_inc < len_reg) begin
                                // fetch the last entry to fill the hole
                                emit       = 1'b0;
                                state_next = B_MOVE;
                            end else begin
                                res_found = 1'b1;
                                len_we    = 1'b1;
                                len_wdata = len_reg - LEN_W'(1);
                                if (count_reg != '0) begin
                                    count_next = count_reg - COUNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            res_found = hit_reg;
                            res_rv    = hit_reg ? hval_reg : '0;
                        end
                    endcase
                end
            end
            B_MOVE: begin
                slot_raddr = {item_reg.bucket, last_pos};
                if (out_free) begin
                    emit       = 1'b1;
                    res_found  = 1'b1;
                    slot_we    = 1'b1;
                    slot_wdata = slot_rdata;
                    len_we     = 1'b1;
                    len_wdata  = len_reg - LEN_W'(1);
                    if (count_reg != '0) begin
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
        if (emit) begin
            state_next = B_IDLE;
            mv_next    = 1'b1;
            md_next    = {3'b000, count_next, res_status, res_rv, res_found};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            count_reg <= '0;
            valid_reg <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        hit_reg  <= hit_next;
        hval_reg <= hval_next;
        md_reg   <= md_next;
    end

endmodule
`default_nettype wire

// ----- rtl/cht_checker.sv -----
// Port-level checks of the chained hash table, bound to the top level.
// Depends on cht_pkg and chained_hash_table.
`default_nettype none
module cht_checker import cht_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid right after reset");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:33] <= STATUS_FULL)
        else $error("undefined status code");

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[44:35] <= COUNT_W'(SLOT_TOTAL))
        else $error("entry total above table size");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[34:33] == STATUS_NOTFOUND || m_tdata[34:33] == STATUS_FULL)
        |-> !m_tdata[0] && m_tdata[32:1] == '0)
        else $error("failed request reports a hit or a value");

endmodule

bind chained_hash_table cht_checker u_cht_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// ----- dv/chained_hash_table_tb.sv -----
// Self-checking testbench of chained_hash_table: directed and random requests over a stream
// port, a behavioral table predicts each result word. Depends on cht_pkg and chained_hash_table.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table_tb;
    import cht_pkg::*;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] key;
        logic [31:0] new_value;
    } req_word_t;

    // Packed from the top down, so found lands in bit 0 as on the port.
    typedef struct packed {
        logic [9:0]  entry_total;
        logic [1:0]  status;
        logic [31:0] read_value;
        logic        found;
    } result_t;

    localparam int IDLE_LIMIT = 20000;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [63:0]      s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    chained_hash_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Shadow table state.
    logic [31:0] tbl_key [SLOT_TOTAL];
    logic [31:0] tbl_val [SLOT_TOTAL];
    int          chain_len [MAX_BUCKETS];
    int          stored_total;
    logic [6:0]  bucket_reg;

    req_word_t   pending_reqs[$];
    result_t     expected_results[$];
    int          errors;
    int          sent_count;
    bit          hold_sender;     // pause sender until drained
    int          hold_off_cycles; // long receiver stall
    int          idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int bucket_for(logic [31:0] k);
        longint unsigned h;
        int unsigned     m;
        logic [31:0]     v;
        h = 0;
        v = k;
        if (!v[31]) begin
            while (v != 0) begin
                h = (h * 311 + (v % 10) + 1) % 64'd1000000007;
                v = v / 10;
            end
        end
        m = (bucket_reg == 0) ? 1 : (bucket_reg > MAX_BUCKETS) ? MAX_BUCKETS : bucket_reg;
        return int'(h % m);
    endfunction

    // Apply one request to the shadow table and return its result word.
    function automatic result_t apply_request(req_word_t r);
        result_t res;
        int b, base, len, pos;
        bit hit;
        res = '0;
        b = bucket_for(r.key);
        base = b * CHAIN_DEPTH;
        len = chain_len[b];
        hit = 0;
        pos = 0;
        while (pos < len && !hit) begin
            if (tbl_key[base + pos] == r.key) hit = 1;
            else pos++;
        end
        if (r.req == REQ_GET || r.req == REQ_PUT) begin
            if (hit) begin
                res.found = 1'b1;
                if (r.req == REQ_PUT) tbl_val[base + pos] = r.new_value;
                res.read_value = tbl_val[base + pos];
            end else if (len >= CHAIN_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                tbl_key[base + len] = r.key;
                tbl_val[base + len] = (r.req == REQ_PUT) ? r.new_value : 32'd0;
                res.read_value = tbl_val[base + len];
                chain_len[b] = len + 1;
                stored_total++;
            end
        end else if (r.req == REQ_ERASE) begin
            if (hit) begin
                res.found = 1'b1;
                tbl_key[base + pos] = tbl_key[base + len - 1];
                tbl_val[base + pos] = tbl_val[base + len - 1];
                chain_len[b] = len - 1;
                if (stored_total > 0) stored_total--;
            end else begin
                res.status = STATUS_NOTFOUND;
            end
        end else if (hit) begin
            res.found = 1'b1;
            res.read_value = tbl_val[base + pos];
        end
        res.entry_total = 10'(stored_total);
        return res;
    endfunction

    // Driver: bursts with random gaps; predict on acceptance.
    int burst_left, gap_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_request(pending_reqs.pop_front()));
                sent_count++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the word
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !hold_sender) begin
                s_tvalid <= 1'b1;
                s_tdata <= {pending_reqs[0].new_value, pending_reqs[0].key};
                s_tuser <= pending_reqs[0].req;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(150, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with a long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            case (sent_count / 64 % 3)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(3, 0) != 0);
                default: m_tready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    // Monitor: compare each result word with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                result_t got, exp_r;
                got = m_tdata[44:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.found !== exp_r.found)
                        $display("%0t: found exp %0d got %0d", $time, exp_r.found, got.found);
                    if (got.read_value !== exp_r.read_value)
                        $display("%0t: read_value exp %h got %h", $time,
                                 exp_r.read_value, got.read_value);
                    if (got.status !== exp_r.status)
                        $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                    if (got.entry_total !== exp_r.entry_total)
                        $display("%0t: entry_total exp %0d got %0d", $time,
                                 exp_r.entry_total, got.entry_total);
                    if (got !== exp_r) errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving anywhere.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Key pools keep chains busy: small positive keys, negatives and zero, some fully random keys.
    function automatic logic [31:0] pick_key(int pool);
        case ($urandom_range(9, 0))
            0: return $urandom;
            1: return -$urandom_range(40, 1);
            2: return 32'd0;
            default: return $urandom_range(pool, 1);
        endcase
    endfunction

    task automatic add_req(logic [1:0] req, logic [31:0] key, logic [31:0] val);
        req_word_t r;
        r.req = req;
        r.key = key;
        r.new_value = val;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_buckets(logic [6:0] n);
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        bucket_reg = n;
    endtask

    task automatic random_phase(int count, int pool);
        repeat (count)
            add_req(2'($urandom_range(3, 0)), pick_key(pool), $urandom);
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        sent_count = 0;
        hold_sender = 0;
        hold_off_cycles = 0;
        idle_cycles = 0;
        stored_total = 0;
        bucket_reg = 7'd1;
        foreach (chain_len[i]) chain_len[i] = 0;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one bucket, fill the chain past full, extreme keys and values.
        add_req(REQ_HAS, 32'd5, 32'd0);
        add_req(REQ_ERASE, 32'd5, 32'd0);
        add_req(REQ_GET, 32'h7FFFFFFF, 32'd0);
        add_req(REQ_PUT, 32'h80000000, 32'hFFFFFFFF);
        add_req(REQ_PUT, 32'd0, 32'h80000000);
        add_req(REQ_PUT, 32'h7FFFFFFF, 32'h7FFFFFFF);
        for (int i = 1; i <= 7; i++) add_req(REQ_PUT, i, i * 1000);
        add_req(REQ_GET, 32'd99, 32'd0);
        add_req(REQ_HAS, 32'h7FFFFFFF, 32'd0);
        add_req(REQ_ERASE, 32'h80000000, 32'd0);
        add_req(REQ_ERASE, 32'd3, 32'd0);
        add_req(REQ_GET, 32'hFFFFFFFF, 32'd0);
        add_req(REQ_HAS, 32'd7, 32'd0);
        wait_drained();

        // Zero and out-of-range bucket counts, then typical ones.
        write_buckets(7'd0);
        random_phase(40, 30);
        wait_drained();
        write_buckets(7'd127);
        random_phase(60, 600);
        // Long receiver stall while the sender keeps offering.
        hold_off_cycles = 3000;
        wait_drained();
        write_buckets(7'd64);
        random_phase(120, 300);
        // Pause the sender midway until every expected result has come.
        while (pending_reqs.size() > 60) @(posedge aclk);
        hold_sender = 1;
        @(posedge aclk);
        while (s_tvalid || expected_results.size() > 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        hold_sender = 0;
        wait_drained();
        write_buckets(7'd3);
        random_phase(120, 60);
        wait_drained();
        write_buckets(7'd1);
        random_phase(80, 20);
        wait_drained();
        write_buckets(7'd17);
        random_phase(80, 200);
        wait_drained();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- chained_hash_table.f -----
rtl/cht_pkg.sv
rtl/cht_ram.sv
rtl/cht_front.sv
rtl/cht_fifo.sv
rtl/cht_back.sv
rtl/chained_hash_table.sv
rtl/cht_checker.sv
dv/chained_hash_table_tb.sv
